FILE: rtl/mbtcp_pkg.sv
// Shared types, constants and codes for the Modbus TCP response matcher.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package mbtcp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int DEPTH_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CFG_W       = 5;
  localparam int SLOT_W      = 4;
  localparam int ENTRY_W     = 56;

  localparam logic [CFG_W-1:0] RING_RESET = CFG_W'(16);

  localparam logic [1:0] CMD_RECORD   = 2'd0;
  localparam logic [1:0] CMD_CHECK    = 2'd1;
  localparam logic [1:0] CMD_ALLOCATE = 2'd2;

  localparam logic [7:0]  MAX_READ_FC = 8'h04;
  localparam logic [15:0] ID_MAX      = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_ACCEPT   = 4'd0,
    ST_RECORDED = 4'd1,
    ST_ISSUED   = 4'd2,
    ST_NOMATCH  = 4'd3,
    ST_PROTO    = 4'd4,
    ST_NOTREAD  = 4'd5,
    ST_LENGTH   = 4'd6,
    ST_FUNC     = 4'd7,
    ST_COUNT    = 4'd8
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  fc;
    logic [15:0] start;
    logic [15:0] qty;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/mbtcp_if.sv
// Valid/ready channel interfaces: request items in, result items out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mbtcp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] transaction_id;
  logic [15:0] protocol_id;
  logic [15:0] length_field;
  logic [7:0]  function_code;
  logic [7:0]  byte_count;
  logic [15:0] start_address;
  logic [15:0] quantity;

  modport source (output valid, command, transaction_id, protocol_id, length_field,
                  function_code, byte_count, start_address, quantity, input ready);
  modport sink (input valid, command, transaction_id, protocol_id, length_field,
                function_code, byte_count, start_address, quantity, output ready);
endinterface

interface mbtcp_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [3:0]  slot;
  logic [7:0]  matched_function;
  logic [15:0] matched_start;
  logic [15:0] matched_quantity;
  logic [15:0] new_transaction_id;

  modport source (output valid, status, slot, matched_function, matched_start,
                  matched_quantity, new_transaction_id, input ready);
  modport sink (input valid, status, slot, matched_function, matched_start,
                matched_quantity, new_transaction_id, output ready);
endinterface

`default_nettype wire

FILE: rtl/mbtcp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mbtcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/modbus_tcp_response_matcher.sv
// Top level: Modbus TCP client transaction matcher with table scan sequencer.
// Depends on mbtcp_pkg, mbtcp_if and mbtcp_ram.
//
//   channel  dir  handshake           payload
//   req      in   valid/ready         command, ids, header, request fields
//   rsp      out  valid/ready         status, slot, matched fields, new id
//   cfg      in   cfg_wr_en           cfg_wr_data = entries_in_use
//
// Record and allocate pass through the done state before the next accept.
// Check scans the ring through the table RAM's registered read port, one
// slot per cycle, until a slot matches or the last slot of the ring is read.
// Reset is synchronous and clears valid marks, pointer and counter.
// Requests are taken only when idle; a held result stalls acceptance.
`timescale 1ns / 1ps
`default_nettype none

module modbus_tcp_response_matcher (
  input  wire logic                      clk,
  input  wire logic                      rst,
  mbtcp_req_if.sink                      req,
  mbtcp_rsp_if.source                    rsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic [mbtcp_pkg::CFG_W-1:0] cfg_wr_data
);
  import mbtcp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EVAL, S_DONE} state_t;

  state_t                 state;
  logic [CFG_W-1:0]       entries_in_use;
  logic [CFG_W-1:0]       ring_n;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [DEPTH_W:0]       write_pointer;
  logic [DEPTH_W:0]       wp_eff;
  logic [15:0]            transaction_counter;
  logic [15:0]            counter_next;

  logic [15:0] q_tid, q_pid, q_len;
  logic [7:0]  q_fc, q_bc;

  logic [DEPTH_W:0]   scan_idx;
  logic [DEPTH_W-1:0] cmp_idx;
  logic               primed;
  entry_t             rd_entry;
  entry_t             hit_entry;
  logic               hit, last;

  status_t     res_status;
  logic [3:0]  res_slot;
  logic [7:0]  res_fc;
  logic [15:0] res_start, res_qty, res_newid;

  logic        out_valid;
  status_t     out_status;
  logic [3:0]  out_slot;
  logic [7:0]  out_fc;
  logic [15:0] out_start, out_qty, out_newid;

  logic        accept;
  logic        table_we;
  entry_t      wr_entry;
  logic [16:0] need, bc_plus3;
  status_t     eval_status;

  assign ring_n = (entries_in_use == '0) ? CFG_W'(1) :
                  (entries_in_use > CFG_W'(TABLE_DEPTH)) ? CFG_W'(TABLE_DEPTH) :
                  entries_in_use;

  assign wp_eff = (write_pointer >= (DEPTH_W+1)'(ring_n)) ? '0 : write_pointer;
  assign counter_next = (transaction_counter == ID_MAX) ? 16'd1 :
                        transaction_counter + 16'd1;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign table_we  = accept && (req.command == CMD_RECORD);
  assign wr_entry  = '{id: req.transaction_id, fc: req.function_code,
                       start: req.start_address, qty: req.quantity};

  mbtcp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (wp_eff[DEPTH_W-1:0]),
    .wdata (wr_entry),
    .raddr (scan_idx[DEPTH_W-1:0]),
    .rdata (rd_entry)
  );

  // id compare on the slot read last cycle
  assign hit  = primed && entry_valid[cmp_idx] && (rd_entry.id == q_tid);
  assign last = primed && ((CFG_W'(cmp_idx) + CFG_W'(1)) == ring_n);

  always_comb begin
    if (hit_entry.fc <= 8'd2) begin
      need = (17'(hit_entry.qty) + 17'd7) >> 3;
    end else begin
      need = {hit_entry.qty, 1'b0};
    end
    bc_plus3 = 17'(q_bc) + 17'd3;
    priority if (q_pid != 16'd0) begin
      eval_status = ST_PROTO;
    end else if (q_fc < 8'd1 || q_fc > MAX_READ_FC) begin
      eval_status = ST_NOTREAD;
    end else if (17'(q_len) != bc_plus3) begin
      eval_status = ST_LENGTH;
    end else if (q_fc != hit_entry.fc) begin
      eval_status = ST_FUNC;
    end else if (need != 17'(q_bc)) begin
      eval_status = ST_COUNT;
    end else begin
      eval_status = ST_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      entries_in_use      <= RING_RESET;
      entry_valid         <= '0;
      write_pointer       <= '0;
      transaction_counter <= '0;
      primed              <= 1'b0;
      scan_idx            <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entries_in_use <= cfg_wr_data;
      end
      // in the done state the output register is either reloaded or left held
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            q_tid      <= req.transaction_id;
            q_pid      <= req.protocol_id;
            q_len      <= req.length_field;
            q_fc       <= req.function_code;
            q_bc       <= req.byte_count;
            res_slot   <= '0;
            res_fc     <= '0;
            res_start  <= '0;
            res_qty    <= '0;
            res_newid  <= '0;
            scan_idx   <= '0;
            primed     <= 1'b0;
            unique case (req.command)
              CMD_RECORD: begin
                entry_valid[wp_eff[DEPTH_W-1:0]] <= 1'b1;
                write_pointer <= wp_eff + (DEPTH_W+1)'(1);
                res_status    <= ST_RECORDED;
                res_slot      <= SLOT_W'(wp_eff);
                state         <= S_DONE;
              end
              CMD_ALLOCATE: begin
                transaction_counter <= counter_next;
                res_status          <= ST_ISSUED;
                res_newid           <= counter_next;
                state               <= S_DONE;
              end
              CMD_CHECK: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            hit_entry <= rd_entry;
            res_slot  <= SLOT_W'(cmp_idx);
            state     <= S_EVAL;
          end else if (last) begin
            res_status <= ST_NOMATCH;
            state      <= S_DONE;
          end else begin
            cmp_idx  <= scan_idx[DEPTH_W-1:0];
            primed   <= 1'b1;
            scan_idx <= scan_idx + (DEPTH_W+1)'(1);
          end
        end
        S_EVAL: begin
          res_status <= eval_status;
          res_fc     <= hit_entry.fc;
          res_start  <= hit_entry.start;
          res_qty    <= hit_entry.qty;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_slot   <= res_slot;
            out_fc     <= res_fc;
            out_start  <= res_start;
            out_qty    <= res_qty;
            out_newid  <= res_newid;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.status             = out_status;
  assign rsp.slot               = out_slot;
  assign rsp.matched_function   = out_fc;
  assign rsp.matched_start      = out_start;
  assign rsp.matched_quantity   = out_qty;
  assign rsp.new_transaction_id = out_newid;

  a_reset_clears_valid: assert property (@(posedge clk)
    rst |=> (entry_valid == '0))
    else $error("valid marks not cleared by reset");

  a_issued_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_ISSUED) |-> (rsp.new_transaction_id != 16'd0))
    else $error("allocate issued id zero");

  a_no_match_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_NOMATCH || rsp.status == ST_RECORDED ||
                   rsp.status == ST_ISSUED))
    |-> (rsp.matched_function == 8'd0 && rsp.matched_quantity == 16'd0))
    else $error("matched fields set without a match");

  a_hit_slot_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit) |=> (CFG_W'(res_slot) < ring_n))
    else $error("match outside ring");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for modbus_tcp_response_matcher: directed table and
// random phases over several ring sizes, checked by an in-bench predictor.
// Depends on mbtcp_pkg, mbtcp_if and the matcher RTL.
`timescale 1ns / 1ps

module tb_top;
  import mbtcp_pkg::*;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam int         SETTLE_CYCLES   = 32;
  localparam int         LONG_HOLD       = 200;
  localparam int         WATCHDOG_LIMIT  = 4000;
  localparam int         ITEMS_PER_PHASE = 50;

  typedef struct {
    logic [1:0]  command;
    logic [15:0] transaction_id;
    logic [15:0] protocol_id;
    logic [15:0] length_field;
    logic [7:0]  function_code;
    logic [7:0]  byte_count;
    logic [15:0] start_address;
    logic [15:0] quantity;
  } request_t;

  typedef struct {
    status_t     status;
    logic [3:0]  slot;
    logic [7:0]  fn;
    logic [15:0] start;
    logic [15:0] qty;
    logic [15:0] new_id;
  } response_t;

  typedef struct {
    request_t  rq;
    bit        typed;
    response_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  mbtcp_req_if req_bus ();
  mbtcp_rsp_if rsp_bus ();

  modbus_tcp_response_matcher dut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_bus),
    .rsp         (rsp_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  entry_t           slot_table [TABLE_DEPTH];
  bit               slot_valid [TABLE_DEPTH];
  int               wr_ptr;
  logic [15:0]      id_counter;
  logic [CFG_W-1:0] ring_cfg;

  response_t pending_responses[$];
  response_t blank_rsp;
  int        mismatches;
  int        stall_requests;
  int        quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic request_t req_of(logic [1:0] cmd, logic [15:0] tid, logic [15:0] pid,
                                      logic [15:0] len, logic [7:0] fc, logic [7:0] bc,
                                      logic [15:0] sa, logic [15:0] qty);
    request_t rq;
    rq.command        = cmd;
    rq.transaction_id = tid;
    rq.protocol_id    = pid;
    rq.length_field   = len;
    rq.function_code  = fc;
    rq.byte_count     = bc;
    rq.start_address  = sa;
    rq.quantity       = qty;
    return rq;
  endfunction

  function automatic response_t rsp_of(status_t st, logic [3:0] slot, logic [7:0] fn,
                                       logic [15:0] start, logic [15:0] qty,
                                       logic [15:0] new_id);
    response_t r;
    r.status = st;
    r.slot   = slot;
    r.fn     = fn;
    r.start  = start;
    r.qty    = qty;
    r.new_id = new_id;
    return r;
  endfunction

  function automatic stim_row_t row(request_t rq, bit typed, response_t want);
    stim_row_t s;
    s.rq    = rq;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic int ring_size();
    if (ring_cfg == 0) return 1;
    if (ring_cfg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(ring_cfg);
  endfunction

  // coils: ceil(qty/8); registers: 2*qty, kept at 17 bits
  function automatic logic [16:0] byte_need(entry_t e);
    return (e.fc <= 8'd2) ? (17'(e.qty) + 17'd7) >> 3 : {e.qty, 1'b0};
  endfunction

  task automatic predict_response(input request_t rq, output bit produced,
                                  output response_t r);
    int n;
    int hit;
    entry_t e;
    r = rsp_of(ST_ACCEPT, 0, 0, 0, 0, 0);
    produced = 1'b1;
    n = ring_size();
    case (rq.command)
      CMD_RECORD: begin
        if (wr_ptr >= n) wr_ptr = 0;
        slot_table[wr_ptr] = '{id: rq.transaction_id, fc: rq.function_code,
                               start: rq.start_address, qty: rq.quantity};
        slot_valid[wr_ptr] = 1'b1;
        r.status = ST_RECORDED;
        r.slot = 4'(wr_ptr);
        wr_ptr++;
      end
      CMD_ALLOCATE: begin
        id_counter = (id_counter == ID_MAX) ? 16'd1 : id_counter + 16'd1;
        r.status = ST_ISSUED;
        r.new_id = id_counter;
      end
      CMD_CHECK: begin
        hit = -1;
        for (int i = 0; i < n; i++)
          if (hit < 0 && slot_valid[i] && slot_table[i].id == rq.transaction_id) hit = i;
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          e = slot_table[hit];
          r.slot  = 4'(hit);
          r.fn    = e.fc;
          r.start = e.start;
          r.qty   = e.qty;
          if (rq.protocol_id != 16'd0) r.status = ST_PROTO;
          else if (rq.function_code < 8'd1 || rq.function_code > MAX_READ_FC)
            r.status = ST_NOTREAD;
          else if (rq.length_field != {8'd0, rq.byte_count} + 16'd3) r.status = ST_LENGTH;
          else if (rq.function_code != e.fc) r.status = ST_FUNC;
          else if (byte_need(e) != 17'(rq.byte_count)) r.status = ST_COUNT;
          else r.status = ST_ACCEPT;
        end
      end
      default: produced = 1'b0;
    endcase
  endtask

  // mostly well-formed traffic: allocate, record the issued id, check a live slot
  function automatic request_t random_request();
    request_t rq;
    int live[$];
    int pick;
    int n;
    entry_t e;
    logic [16:0] need;
    rq = req_of(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    n = ring_size();
    if (pick < 4) return rq;
    if (pick < 26) begin
      rq.command = CMD_ALLOCATE;
      return rq;
    end
    if (pick < 56) begin
      rq.command = CMD_RECORD;
      case ($urandom_range(0, 4))
        0, 1, 2: rq.transaction_id = id_counter;
        3:       rq.transaction_id = 16'($urandom_range(0, 7));
        default: ;
      endcase
      if ($urandom_range(0, 4) != 0) rq.function_code = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 9) != 0)
        rq.quantity = (rq.function_code <= 8'd2) ? 16'($urandom_range(0, 2040))
                                                 : 16'($urandom_range(0, 127));
      return rq;
    end
    rq.command = CMD_CHECK;
    for (int i = 0; i < n; i++)
      if (slot_valid[i]) live.push_back(i);
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return rq;
    e = slot_table[live[$urandom_range(0, live.size() - 1)]];
    need = byte_need(e);
    rq.transaction_id = e.id;
    rq.protocol_id    = 16'd0;
    rq.function_code  = e.fc;
    rq.byte_count     = need[7:0];
    rq.length_field   = {8'd0, rq.byte_count} + 16'd3;
    case ($urandom_range(0, 9))
      0: rq.protocol_id = 16'($urandom_range(1, 65535));
      1: rq.function_code = 8'($urandom);
      2: rq.length_field = 16'($urandom);
      3: begin
        rq.byte_count   = 8'($urandom);
        rq.length_field = {8'd0, rq.byte_count} + 16'd3;
      end
      default: ;
    endcase
    return rq;
  endfunction

  function automatic int gap_cycles(bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic string show(response_t r);
    return $sformatf("st=%0d slot=%0d fc=%0h start=%0h qty=%0h id=%0h",
                     r.status, r.slot, r.fn, r.start, r.qty, r.new_id);
  endfunction

  task automatic note_mismatch(string want_s, response_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: expected %s, got %s", $time, want_s, show(got));
  endtask

  // valid is left high; the caller lowers it only for a gap or a drain
  task automatic send_request(request_t rq, bit typed, response_t want);
    bit produced;
    response_t r;
    req_bus.valid          <= 1'b1;
    req_bus.command        <= rq.command;
    req_bus.transaction_id <= rq.transaction_id;
    req_bus.protocol_id    <= rq.protocol_id;
    req_bus.length_field   <= rq.length_field;
    req_bus.function_code  <= rq.function_code;
    req_bus.byte_count     <= rq.byte_count;
    req_bus.start_address  <= rq.start_address;
    req_bus.quantity       <= rq.quantity;
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
    predict_response(rq, produced, r);
    if (produced) pending_responses.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    if (cycles == 0) return;
    req_bus.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_requests();
    req_bus.valid <= 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_ring_size(logic [CFG_W-1:0] value);
    drain_requests();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ring_cfg = value;
  endtask

  initial begin : result_sink
    int hold_left;
    int run_left;
    int stalls_done;
    hold_left = 0;
    run_left = 0;
    stalls_done = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else if (stalls_done != stall_requests) begin
        stalls_done++;
        hold_left = LONG_HOLD - 1;
        rsp_bus.ready <= 1'b0;
      end else if (run_left > 0) begin
        rsp_bus.ready <= 1'b1;
        run_left--;
      end else begin
        rsp_bus.ready <= 1'b0;
        hold_left = gap_cycles(1'b0) - 1;
        run_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 20)
                                                : $urandom_range(100, 300);
      end
    end
  end

  always @(posedge clk) begin : check_results
    response_t got;
    response_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got = rsp_of(status_t'(rsp_bus.status), rsp_bus.slot, rsp_bus.matched_function,
                   rsp_bus.matched_start, rsp_bus.matched_quantity,
                   rsp_bus.new_transaction_id);
      if (pending_responses.size() == 0) begin
        note_mismatch("none", got);
      end else begin
        want = pending_responses.pop_front();
        if (got.status !== want.status || got.slot !== want.slot || got.fn !== want.fn ||
            got.start !== want.start || got.qty !== want.qty || got.new_id !== want.new_id)
          note_mismatch(show(want), got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("modbus_tcp_response_matcher: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : request_source
    stim_row_t        directed_rows[$];
    logic [CFG_W-1:0] ring_plan[8];
    bit               tight;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_bus.valid = 1'b0;
    req_bus.command = CMD_RECORD;
    req_bus.transaction_id = '0;
    req_bus.protocol_id = '0;
    req_bus.length_field = '0;
    req_bus.function_code = '0;
    req_bus.byte_count = '0;
    req_bus.start_address = '0;
    req_bus.quantity = '0;
    mismatches = 0;
    stall_requests = 0;
    quiet_cycles = 0;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    wr_ptr = 0;
    id_counter = 16'd0;
    ring_cfg = RING_RESET;
    blank_rsp = rsp_of(ST_ACCEPT, 0, 0, 0, 0, 0);
    ring_plan = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd3, 5'd17, 5'd8, 5'd2};

    directed_rows.push_back(row(req_of(CMD_CHECK, 0, 0, 3, 1, 0, 0, 0), 1,
                                rsp_of(ST_NOMATCH, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row(req_of(CMD_ALLOCATE, 0, 0, 0, 0, 0, 0, 0), 1,
                                rsp_of(ST_ISSUED, 0, 0, 0, 0, 1)));
    directed_rows.push_back(row(req_of(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                                       8'hFF, 16'hFFFF, 16'hFFFF), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_ALLOCATE, 0, 0, 0, 0, 0, 0, 0), 1,
                                rsp_of(ST_ISSUED, 0, 0, 0, 0, 2)));
    directed_rows.push_back(row(req_of(CMD_RECORD, 1, 0, 0, 1, 0, 0, 0), 1,
                                rsp_of(ST_RECORDED, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row(req_of(CMD_RECORD, 2, 0, 0, 2, 0, 16'hFFFF, 16'hFFFF), 1,
                                rsp_of(ST_RECORDED, 1, 0, 0, 0, 0)));
    directed_rows.push_back(row(req_of(CMD_RECORD, 3, 0, 0, 3, 0, 16'h1234, 125), 1,
                                rsp_of(ST_RECORDED, 2, 0, 0, 0, 0)));
    directed_rows.push_back(row(req_of(CMD_RECORD, 16'hFFFF, 0, 0, 4, 0, 16'h8000,
                                       16'hFFFF), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_RECORD, 5, 0, 0, 8'hFF, 0, 1, 8), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 1, 0, 3, 1, 0, 0, 0), 1,
                                rsp_of(ST_ACCEPT, 0, 1, 0, 0, 0)));
    directed_rows.push_back(row(req_of(CMD_CHECK, 2, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 0, 0),
                                1, rsp_of(ST_PROTO, 1, 2, 16'hFFFF, 16'hFFFF, 0)));
    directed_rows.push_back(row(req_of(CMD_CHECK, 2, 0, 3, 0, 0, 0, 0), 1,
                                rsp_of(ST_NOTREAD, 1, 2, 16'hFFFF, 16'hFFFF, 0)));
    directed_rows.push_back(row(req_of(CMD_CHECK, 2, 0, 3, 5, 0, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 3, 0, 16'hFFFF, 3, 250, 0, 0), 0,
                                blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 3, 0, 253, 4, 250, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 3, 0, 253, 3, 250, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 3, 0, 252, 3, 249, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 16'hFFFF, 0, 258, 4, 8'hFF, 0, 0), 0,
                                blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 2, 0, 3, 2, 0, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_RECORD, 1, 0, 0, 3, 0, 7, 1), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 1, 0, 3, 1, 0, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 5, 0, 4, 1, 1, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_RECORD, 6, 0, 0, 2, 0, 16'h00FF, 9), 0,
                                blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 6, 0, 5, 2, 2, 0, 0), 0, blank_rsp));
    directed_rows.push_back(row(req_of(CMD_CHECK, 16'h1234, 0, 3, 1, 0, 0, 0), 0,
                                blank_rsp));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
      idle_sender(gap_cycles(1'b1));
    end

    foreach (ring_plan[p]) begin
      set_ring_size(ring_plan[p]);
      tight = (p == 2 || p == 5);
      if (tight) stall_requests <= stall_requests + 1;
      repeat (ITEMS_PER_PHASE) begin
        send_request(random_request(), 1'b0, blank_rsp);
        if (!tight) idle_sender(gap_cycles(1'b1));
      end
    end

    drain_requests();
    if (mismatches == 0) begin
      $display("modbus_tcp_response_matcher: match");
    end else begin
      $display("modbus_tcp_response_matcher: mismatch");
    end
    $finish;
  end

endmodule
